@@ src/dgg_pkg.sv @@
package dgg_pkg;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 10;
    localparam int STEP_W   = 2;
    localparam int ORIGIN_W = 10;
    localparam int SIZE_W   = 11;
    localparam int RANGE_W  = 7;
    localparam int GLYPH_W  = 3;
    localparam int CUR_W    = 8;
    localparam int SCR_W    = 12;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 11;

    // stream packing
    localparam int S_TDATA_W = 32;
    localparam int M_FIELDS_W = GLYPH_W + 2 * CUR_W + 2 * SCR_W;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // diamond geometry
    localparam int HALF_WIDTH  = 4;
    localparam int HALF_HEIGHT = 2;
    localparam int CELL        = 2 * HALF_WIDTH * HALF_HEIGHT;
    localparam int CELL_BITS   = $clog2(CELL);

    // glyph arithmetic width, covers every intermediate value
    localparam int CALC_W = 16;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MOVE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd2;

    // glyph codes
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 3'd0;
    localparam logic [GLYPH_W-1:0] GLYPH_SLASH = 3'd1;
    localparam logic [GLYPH_W-1:0] GLYPH_BSLSH = 3'd2;
    localparam logic [GLYPH_W-1:0] GLYPH_PLUS  = 3'd3;
    localparam logic [GLYPH_W-1:0] GLYPH_FILL  = 3'd4;
    localparam logic [GLYPH_W-1:0] GLYPH_AT    = 3'd5;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ORIGIN_COL  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_ROW  = 3'd1;
    localparam logic [IDX_W-1:0] REG_SCREEN_ROWS = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCREEN_COLS = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROAM_RANGE  = 3'd4;

    // register reset values
    localparam logic [ORIGIN_W-1:0] RST_ORIGIN_COL  = 10'd40;
    localparam logic [ORIGIN_W-1:0] RST_ORIGIN_ROW  = 10'd11;
    localparam logic [SIZE_W-1:0]   RST_SCREEN_ROWS = 11'd24;
    localparam logic [SIZE_W-1:0]   RST_SCREEN_COLS = 11'd80;
    localparam logic [RANGE_W-1:0]  RST_ROAM_RANGE  = 7'd8;

    typedef struct packed {
        logic signed [CUR_W-1:0] row;
        logic signed [CUR_W-1:0] col;
        logic signed [SCR_W-1:0] scr_row;
        logic signed [SCR_W-1:0] scr_col;
    } cursor_t;

endpackage

@@ src/dgg_cursor.sv @@
module dgg_cursor (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               advance,
    input  logic [dgg_pkg::FUNC_W-1:0]         func,
    input  logic signed [dgg_pkg::STEP_W-1:0]  step_row,
    input  logic signed [dgg_pkg::STEP_W-1:0]  step_col,
    input  logic [dgg_pkg::RANGE_W-1:0]        roam_range,
    input  logic [dgg_pkg::ORIGIN_W-1:0]       origin_row,
    input  logic [dgg_pkg::ORIGIN_W-1:0]       origin_col,
    output dgg_pkg::cursor_t                   cursor
);

    localparam int TRY_W = dgg_pkg::CUR_W + 1;

    logic signed [dgg_pkg::CUR_W-1:0] cur_row_reg, cur_row_next;
    logic signed [dgg_pkg::CUR_W-1:0] cur_col_reg, cur_col_next;
    logic signed [TRY_W-1:0]          row_try, col_try, lim;
    logic                             row_ok, col_ok;
    logic signed [TRY_W-1:0]          sum_rc, diff_cr;

    always_comb begin
        lim     = signed'(TRY_W'(roam_range));
        row_try = TRY_W'(cur_row_reg) + TRY_W'(step_row);
        col_try = TRY_W'(cur_col_reg) + TRY_W'(step_col);
        row_ok  = (row_try >= -lim) && (row_try <= lim);
        col_ok  = (col_try >= -lim) && (col_try <= lim);

        unique case (func)
            dgg_pkg::FUNC_MOVE: begin
                cur_row_next = row_ok ? row_try[dgg_pkg::CUR_W-1:0] : cur_row_reg;
                cur_col_next = col_ok ? col_try[dgg_pkg::CUR_W-1:0] : cur_col_reg;
            end
            dgg_pkg::FUNC_RESET: begin
                cur_row_next = '0;
                cur_col_next = '0;
            end
            default: begin
                cur_row_next = cur_row_reg;
                cur_col_next = cur_col_reg;
            end
        endcase

        sum_rc  = TRY_W'(cur_col_next) + TRY_W'(cur_row_next);
        diff_cr = TRY_W'(cur_col_next) - TRY_W'(cur_row_next);

        cursor.row     = cur_row_next;
        cursor.col     = cur_col_next;
        cursor.scr_row = dgg_pkg::SCR_W'(signed'(dgg_pkg::SCR_W'(origin_row))
                         + sum_rc * dgg_pkg::HALF_HEIGHT);
        cursor.scr_col = dgg_pkg::SCR_W'(signed'(dgg_pkg::SCR_W'(origin_col))
                         + diff_cr * dgg_pkg::HALF_WIDTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end else if (advance) begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
        end
    end

endmodule

@@ src/dgg_glyph.sv @@
module dgg_glyph (
    input  logic                          is_query,
    input  logic [dgg_pkg::COORD_W-1:0]   screen_row,
    input  logic [dgg_pkg::COORD_W-1:0]   screen_col,
    input  logic [dgg_pkg::ORIGIN_W-1:0]  origin_row,
    input  logic [dgg_pkg::ORIGIN_W-1:0]  origin_col,
    input  logic [dgg_pkg::SIZE_W-1:0]    screen_rows,
    input  logic [dgg_pkg::SIZE_W-1:0]    screen_cols,
    input  dgg_pkg::cursor_t              cursor,
    output logic [dgg_pkg::GLYPH_W-1:0]   glyph
);

    localparam int W = dgg_pkg::CALC_W;

    logic signed [W-1:0] sr, sc, rows, cols, csr, csc;
    logic signed [W-1:0] u, v, cx, rx, cx_off, rx_off, dr, dc;
    logic                col_edge, row_edge, drawable, near, cursor_hit, at_spot;
    logic [dgg_pkg::GLYPH_W-1:0] lat;

    always_comb begin
        sr   = signed'(W'(screen_row));
        sc   = signed'(W'(screen_col));
        rows = signed'(W'(screen_rows));
        cols = signed'(W'(screen_cols));
        csr  = W'(cursor.scr_row);
        csc  = W'(cursor.scr_col);

        u  = sc - signed'(W'(origin_col));
        v  = sr - signed'(W'(origin_row));
        cx = W'(u * dgg_pkg::HALF_HEIGHT + v * dgg_pkg::HALF_WIDTH);
        rx = W'(v * dgg_pkg::HALF_WIDTH - u * dgg_pkg::HALF_HEIGHT);

        // lattice lines fall on whole cell multiples
        col_edge = (cx[dgg_pkg::CELL_BITS-1:0] == '0);
        row_edge = (rx[dgg_pkg::CELL_BITS-1:0] == '0);

        if (col_edge && row_edge) begin
            lat = dgg_pkg::GLYPH_PLUS;
        end else if (col_edge) begin
            lat = dgg_pkg::GLYPH_SLASH;
        end else if (row_edge) begin
            lat = dgg_pkg::GLYPH_BSLSH;
        end else begin
            lat = dgg_pkg::GLYPH_BLANK;
        end

        // cursor diamond, lower and right edges included
        cx_off = cx - W'(cursor.col * dgg_pkg::CELL);
        rx_off = rx - W'(cursor.row * dgg_pkg::CELL);
        cursor_hit = (cx_off > 0) && (cx_off <= dgg_pkg::CELL)
                  && (rx_off > 0) && (rx_off <= dgg_pkg::CELL);

        dr   = sr - csr;
        dc   = sc - csc;
        near = (dr >= -2 * dgg_pkg::HALF_HEIGHT) && (dr <= 2 * dgg_pkg::HALF_HEIGHT)
            && (dc >= -2 * dgg_pkg::HALF_WIDTH) && (dc <= 2 * dgg_pkg::HALF_WIDTH);

        drawable = (sr < rows - 1) && (sc < cols);

        at_spot = (csr >= 0) && (csr < rows - 1) && (csc >= 0) && (csc < cols)
               && (sr == csr + dgg_pkg::HALF_HEIGHT) && (sc == csc) && (sr < rows);

        if (!is_query) begin
            glyph = dgg_pkg::GLYPH_BLANK;
        end else if (at_spot) begin
            glyph = dgg_pkg::GLYPH_AT;
        end else if (!drawable) begin
            glyph = dgg_pkg::GLYPH_BLANK;
        end else if (lat == dgg_pkg::GLYPH_BLANK && near && cursor_hit) begin
            glyph = dgg_pkg::GLYPH_FILL;
        end else begin
            glyph = lat;
        end
    end

endmodule

@@ src/diamond_grid_glyph_with_cursor.sv @@
// character generator for a 45 degree rotated square grid with a movable cursor cell.
// each transaction on the s_ side is a query (screen spot to glyph), a cursor move or
// a cursor reset; each gives exactly one transaction on the m_ side carrying the glyph
// and the cursor position after it. one transaction is taken every clock: an input
// register feeds a single pass of glyph and cursor logic into an output register, so a
// result is offered on the m_ side once it has moved from the input register into the
// output register, and s_tready drops only when both registers are full and m_tready
// is low. the cursor state updates as an item leaves the input register, so back-to-back
// moves and queries see each other in order.
// configuration writes on the cfg_ port are always taken and belong only to idle time.
module diamond_grid_glyph_with_cursor (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // func[1:0], screen_row[11:2], screen_col[21:12], step_row[23:22], step_col[25:24]
    input  logic [dgg_pkg::S_TDATA_W-1:0]    s_tdata,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // glyph[2:0], cursor_row[10:3], cursor_col[18:11], cursor_screen_row[30:19],
    // cursor_screen_col[42:31]
    output logic [dgg_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dgg_pkg::IDX_W-1:0]        cfg_index,
    input  logic [dgg_pkg::CFG_W-1:0]        cfg_data
);

    // configuration registers
    logic [dgg_pkg::ORIGIN_W-1:0] origin_col_reg, origin_row_reg;
    logic [dgg_pkg::SIZE_W-1:0]   screen_rows_reg, screen_cols_reg;
    logic [dgg_pkg::RANGE_W-1:0]  roam_range_reg;

    // input register
    logic                               in_valid_reg;
    logic [dgg_pkg::FUNC_W-1:0]         in_func_reg;
    logic [dgg_pkg::COORD_W-1:0]        in_row_reg, in_col_reg;
    logic signed [dgg_pkg::STEP_W-1:0]  in_step_row_reg, in_step_col_reg;

    // output register
    logic                               out_valid_reg;
    logic [dgg_pkg::GLYPH_W-1:0]        out_glyph_reg;
    dgg_pkg::cursor_t                   out_cursor_reg;

    logic                               out_free, advance;
    dgg_pkg::cursor_t                   cursor;
    logic [dgg_pkg::GLYPH_W-1:0]        glyph;

    // config port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_col_reg  <= dgg_pkg::RST_ORIGIN_COL;
            origin_row_reg  <= dgg_pkg::RST_ORIGIN_ROW;
            screen_rows_reg <= dgg_pkg::RST_SCREEN_ROWS;
            screen_cols_reg <= dgg_pkg::RST_SCREEN_COLS;
            roam_range_reg  <= dgg_pkg::RST_ROAM_RANGE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dgg_pkg::REG_ORIGIN_COL:  origin_col_reg  <= cfg_data[dgg_pkg::ORIGIN_W-1:0];
                dgg_pkg::REG_ORIGIN_ROW:  origin_row_reg  <= cfg_data[dgg_pkg::ORIGIN_W-1:0];
                dgg_pkg::REG_SCREEN_ROWS: screen_rows_reg <= cfg_data;
                dgg_pkg::REG_SCREEN_COLS: screen_cols_reg <= cfg_data;
                dgg_pkg::REG_ROAM_RANGE:  roam_range_reg  <= cfg_data[dgg_pkg::RANGE_W-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // pipeline flow: output slot frees when empty or being taken
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input payload, unpacked from the lowest bit up
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg     <= s_tdata[1:0];
            in_row_reg      <= s_tdata[11:2];
            in_col_reg      <= s_tdata[21:12];
            in_step_row_reg <= s_tdata[23:22];
            in_step_col_reg <= s_tdata[25:24];
        end
    end

    // cursor state and its screen position
    dgg_cursor u_cursor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .func       (in_func_reg),
        .step_row   (in_step_row_reg),
        .step_col   (in_step_col_reg),
        .roam_range (roam_range_reg),
        .origin_row (origin_row_reg),
        .origin_col (origin_col_reg),
        .cursor     (cursor)
    );

    // glyph lookup against the post-item cursor
    dgg_glyph u_glyph (
        .is_query    (in_func_reg == dgg_pkg::FUNC_QUERY),
        .screen_row  (in_row_reg),
        .screen_col  (in_col_reg),
        .origin_row  (origin_row_reg),
        .origin_col  (origin_col_reg),
        .screen_rows (screen_rows_reg),
        .screen_cols (screen_cols_reg),
        .cursor      (cursor),
        .glyph       (glyph)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result payload, held while stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_glyph_reg  <= glyph;
            out_cursor_reg <= cursor;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{dgg_pkg::M_PAD_W{1'b0}},
                       out_cursor_reg.scr_col,
                       out_cursor_reg.scr_row,
                       out_cursor_reg.col,
                       out_cursor_reg.row,
                       out_glyph_reg};

endmodule

@@ src/dgg_checker.sv @@
module dgg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dgg_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int ROW_LSB = dgg_pkg::GLYPH_W;
    localparam int COL_LSB = ROW_LSB + dgg_pkg::CUR_W;
    localparam int SR_MSB  = COL_LSB + dgg_pkg::CUR_W + dgg_pkg::SCR_W - 1;
    localparam int SC_MSB  = SR_MSB + dgg_pkg::SCR_W;

    logic [dgg_pkg::GLYPH_W-1:0] glyph;
    logic [dgg_pkg::CUR_W-1:0]   crow, ccol;

    assign glyph = m_tdata[dgg_pkg::GLYPH_W-1:0];
    assign crow  = m_tdata[ROW_LSB +: dgg_pkg::CUR_W];
    assign ccol  = m_tdata[COL_LSB +: dgg_pkg::CUR_W];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // only the six glyph codes
    a_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> glyph <= dgg_pkg::GLYPH_AT)
        else $error("glyph code out of range");

    // cursor stays within seven bits of magnitude
    a_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> crow != 8'h80 && ccol != 8'h80)
        else $error("cursor beyond roam limit");

    // at sign only when the cursor top corner is not above or left of the screen
    a_at: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && glyph == dgg_pkg::GLYPH_AT |-> !m_tdata[SR_MSB] && !m_tdata[SC_MSB])
        else $error("at sign with cursor off screen");

endmodule

bind diamond_grid_glyph_with_cursor dgg_checker u_dgg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
